>>> rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants for the three-point delta kernel.
// ----------------------------------------------------------------------------
package tpd_pkg;

  // Fixed-point formats at the ports
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned SPACING_W       = 32;
  localparam int unsigned DIM_W           = 2;
  localparam int unsigned WEIGHT_W        = 48;   // axis weight, Q.32
  localparam int unsigned HALF_W          = 24;   // partial-product slice
  localparam int unsigned RESULT_W        = 63;
  localparam int unsigned KERNEL_FRAC_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 1'd1;

  // Register reset values and codes
  localparam logic [SPACING_W-1:0] INV_SPACING_RST = 32'd65536;
  localparam logic [DIM_W-1:0]     DIM_3D          = 2'd3;

  localparam logic [RESULT_W-1:0] MAX_WEIGHT = {RESULT_W{1'b1}};

  // Lane result handed to the merge stage
  typedef struct packed {
    logic                vld;
    logic [WEIGHT_W-1:0] w;
  } lane_out_t;

endpackage

>>> rtl/three_point_delta_kernel_top.sv
// Three-point discrete delta kernel. Each transaction carries one grid point and
// one marker; the block returns one weight for it. One transaction is taken per
// clock unless the output stalls, and results leave in order through the
// bit-per-stage square-root pipeline in each axis lane and the five-stage
// partial-product merge. The whole pipeline holds while a result waits on
// m_axis_tready. Write registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
// three_point_delta_kernel_top
// Three axis lanes in parallel feeding a saturating product merge.
// ----------------------------------------------------------------------------
module three_point_delta_kernel_top #(
  parameter int unsigned KERNEL_FRAC_BITS = tpd_pkg::KERNEL_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // grid_x, grid_y, grid_z, marker_x, marker_y, marker_z (32 bits each)
  input  logic [191:0]                      s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // delta_weight [62:0], zero pad [63]
  output logic [63:0]                       m_axis_tdata,
  // weight_saturated
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tpd_pkg::*;

  logic [SPACING_W-1:0] inv_spacing;
  logic [DIM_W-1:0]     dim_count;
  logic                 en;
  logic                 res_vld;
  logic [RESULT_W-1:0]  res_weight;
  logic                 res_sat;
  lane_out_t            lane_x;
  lane_out_t            lane_y;
  lane_out_t            lane_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing <= INV_SPACING_RST;
      dim_count   <= DIM_3D;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_SPACING: inv_spacing <= cfg_data;
        REG_DIM_COUNT:   dim_count   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is stuck at the output
  assign en            = !res_vld || m_axis_tready;
  assign s_axis_tready = en;

  tpd_lane #(.FRAC_BITS(KERNEL_FRAC_BITS)) u_lane_x (
    .clk, .rst, .en,
    .in_vld      (s_axis_tvalid),
    .grid        (s_axis_tdata[31:0]),
    .marker      (s_axis_tdata[127:96]),
    .inv_spacing (inv_spacing),
    .lane_out    (lane_x)
  );

  tpd_lane #(.FRAC_BITS(KERNEL_FRAC_BITS)) u_lane_y (
    .clk, .rst, .en,
    .in_vld      (s_axis_tvalid),
    .grid        (s_axis_tdata[63:32]),
    .marker      (s_axis_tdata[159:128]),
    .inv_spacing (inv_spacing),
    .lane_out    (lane_y)
  );

  tpd_lane #(.FRAC_BITS(KERNEL_FRAC_BITS)) u_lane_z (
    .clk, .rst, .en,
    .in_vld      (s_axis_tvalid),
    .grid        (s_axis_tdata[95:64]),
    .marker      (s_axis_tdata[191:160]),
    .inv_spacing (inv_spacing),
    .lane_out    (lane_z)
  );

  tpd_merge u_merge (
    .clk, .rst, .en,
    .three_d    (dim_count == DIM_3D),
    .lane_x     (lane_x),
    .lane_y     (lane_y),
    .lane_z     (lane_z),
    .res_vld    (res_vld),
    .res_weight (res_weight),
    .res_sat    (res_sat)
  );

  assign m_axis_tvalid = res_vld;
  assign m_axis_tdata  = {1'b0, res_weight};
  assign m_axis_tuser  = res_sat;

`ifndef SYNTHESIS
  // a held result freezes the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // lanes run in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    lane_x.vld == lane_y.vld && lane_x.vld == lane_z.vld)
    else $error("lane valids out of step");

  // a clipped result carries the maximum weight
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[62:0] == MAX_WEIGHT)
    else $error("saturated result not at maximum");
`endif

endmodule

>>> rtl/tpd_lane.sv
// ----------------------------------------------------------------------------
// tpd_lane
// One axis of the kernel: distance, branch select, pipelined square root,
// divide by three or six and scaling by the reciprocal spacing.
// ----------------------------------------------------------------------------
module tpd_lane #(
  parameter int unsigned FRAC_BITS = tpd_pkg::KERNEL_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [tpd_pkg::COORD_W-1:0]      grid,
  input  logic [tpd_pkg::COORD_W-1:0]      marker,
  input  logic [tpd_pkg::SPACING_W-1:0]    inv_spacing,
  output tpd_pkg::lane_out_t               lane_out
);
  import tpd_pkg::*;

  localparam int unsigned RW  = FRAC_BITS + 1;      // root bits, also rf bits
  localparam int unsigned TW  = 2 * FRAC_BITS + 2;  // radicand bits
  localparam int unsigned NW  = FRAC_BITS + 3;      // numerator bits
  localparam int unsigned DS  = NW + 2;             // reciprocal shift
  localparam logic [DS-1:0] DM = DS'((2 ** DS) / 3 + 1);
  localparam int unsigned PHW = 25;                 // phi aligned to Q.24
  localparam int unsigned PWW = PHW + SPACING_W;
  localparam logic [RW-1:0] ONE = RW'(1) << FRAC_BITS;

  typedef enum logic [1:0] {BR_ZERO, BR_INNER, BR_OUTER} branch_t;

  // stage 1: absolute distance
  logic              s1_vld;
  logic [31:0]       ad;
  logic signed [32:0] diff;
  assign diff = $signed({grid[31], grid}) - $signed({marker[31], marker});

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= in_vld;
    if (en) ad <= diff[32] ? 32'(-diff) : diff[31:0];
  end

  // stage 2: scaled distance p, Q32.32
  logic        s2_vld;
  logic [63:0] p;
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
    if (en) p <= 64'(ad) * 64'(inv_spacing);
  end

  // stage 3: branch select and argument u
  logic                 s3_vld;
  branch_t              s3_br;
  logic [RW-1:0]        s3_rf;
  logic [FRAC_BITS-1:0] s3_u;
  logic [RW-1:0]        rf;
  logic [RW-1:0]        rf_dist;
  branch_t              br;
  assign rf      = p[32-FRAC_BITS +: RW];
  assign rf_dist = (rf > ONE) ? rf - ONE : ONE - rf;
  always_comb begin
    if (p < 64'h8000_0000) br = BR_INNER;
    else if (p <= 64'h1_8000_0000) br = BR_OUTER;
    else br = BR_ZERO;
  end

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (en) s3_vld <= s2_vld;
    if (en) begin
      s3_br <= br;
      s3_rf <= rf;
      s3_u  <= (br == BR_INNER) ? rf[FRAC_BITS-1:0] : rf_dist[FRAC_BITS-1:0];
    end
  end

  // stage 4: u squared
  logic                   s4_vld;
  branch_t                s4_br;
  logic [RW-1:0]          s4_rf;
  logic [2*FRAC_BITS-1:0] usq;
  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (en) s4_vld <= s3_vld;
    if (en) begin
      s4_br <= s3_br;
      s4_rf <= s3_rf;
      usq   <= (2*FRAC_BITS)'(s3_u) * (2*FRAC_BITS)'(s3_u);
    end
  end

  // stage 5: radicand 1 - 3u^2 loads the root pipeline
  logic [TW-1:0] sq_rem  [0:RW];
  logic [RW-1:0] sq_root [0:RW];
  logic          sq_vld  [0:RW];
  branch_t       sq_br   [0:RW];
  logic [RW-1:0] sq_rf   [0:RW];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= s4_vld;
    if (en) begin
      sq_rem[0]  <= (TW'(1) << (2 * FRAC_BITS)) - (TW'(usq) + TW'({usq, 1'b0}));
      sq_root[0] <= '0;
      sq_br[0]   <= s4_br;
      sq_rf[0]   <= s4_rf;
    end
  end

  // root pipeline, one result bit per stage, most significant first
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int unsigned K = RW - 1 - j;
    logic [TW-1:0] trial;
    assign trial = (TW'(sq_root[j]) << (K + 1)) | (TW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) sq_vld[j+1] <= 1'b0;
      else if (en) sq_vld[j+1] <= sq_vld[j];
      if (en) begin
        sq_br[j+1] <= sq_br[j];
        sq_rf[j+1] <= sq_rf[j];
        if (sq_rem[j] >= trial) begin
          sq_rem[j+1]  <= sq_rem[j] - trial;
          sq_root[j+1] <= sq_root[j] | (RW'(1) << K);
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
      end
    end
  end

  // numerator: one + s, or half of (5 - 3r - s) clamped at zero, or zero when far
  logic          nm_vld;
  logic [NW-1:0] num;
  logic [NW-1:0] outer_a;
  logic [NW-1:0] outer_b;
  logic [NW-1:0] num_next;
  assign outer_a = NW'(ONE) * NW'(5);
  assign outer_b = NW'(sq_rf[RW]) * NW'(3) + NW'(sq_root[RW]);
  always_comb begin
    case (sq_br[RW])
      BR_INNER: num_next = NW'(ONE) + NW'(sq_root[RW]);
      BR_OUTER: num_next = (outer_a >= outer_b) ? (outer_a - outer_b) >> 1 : '0;
      default:  num_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) nm_vld <= 1'b0;
    else if (en) nm_vld <= sq_vld[RW];
    if (en) num <= num_next;
  end

  // divide by three through a reciprocal multiply
  logic             dv_vld;
  logic [NW+DS-1:0] quot_prod;
  always_ff @(posedge clk) begin
    if (rst) dv_vld <= 1'b0;
    else if (en) dv_vld <= nm_vld;
    if (en) quot_prod <= (NW+DS)'(num) * (NW+DS)'(DM);
  end

  // axis weight = phi / h, Q.32
  logic             wt_vld;
  logic [PWW-1:0]   wprod;
  logic [PHW-1:0]   phi_al;
  assign phi_al = PHW'(quot_prod[DS +: RW]) << (24 - FRAC_BITS);
  always_ff @(posedge clk) begin
    if (rst) wt_vld <= 1'b0;
    else if (en) wt_vld <= dv_vld;
    if (en) wprod <= PWW'(phi_al) * PWW'(inv_spacing);
  end

  assign lane_out.vld = wt_vld;
  assign lane_out.w   = wprod[8 +: WEIGHT_W];

endmodule

>>> rtl/tpd_merge.sv
// ----------------------------------------------------------------------------
// tpd_merge
// Multiplies the axis weights in 24-bit partial products, truncates to Q.32
// and saturates the result.
// ----------------------------------------------------------------------------
module tpd_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              three_d,
  input  tpd_pkg::lane_out_t                lane_x,
  input  tpd_pkg::lane_out_t                lane_y,
  input  tpd_pkg::lane_out_t                lane_z,
  output logic                              res_vld,
  output logic [tpd_pkg::RESULT_W-1:0]      res_weight,
  output logic                              res_sat
);
  import tpd_pkg::*;

  localparam int unsigned PW = 2 * WEIGHT_W;   // x*y product
  localparam int unsigned LW = PW + HALF_W;    // P times one half of z
  localparam int unsigned QW = PW + WEIGHT_W;  // full 3D product

  // M1: x*y partial products
  logic                  m1_vld;
  logic [2*HALF_W-1:0]   pp [0:3];
  logic [WEIGHT_W-1:0]   m1_z;
  always_ff @(posedge clk) begin
    if (rst) m1_vld <= 1'b0;
    else if (en) m1_vld <= lane_x.vld;
    if (en) begin
      m1_z <= lane_z.w;
      for (int a = 0; a < 2; a++) begin
        for (int b = 0; b < 2; b++) begin
          pp[a*2+b] <= (2*HALF_W)'(lane_x.w[HALF_W*a +: HALF_W])
                     * (2*HALF_W)'(lane_y.w[HALF_W*b +: HALF_W]);
        end
      end
    end
  end

  // M2: x*y sum
  logic                m2_vld;
  logic [PW-1:0]       prod_xy;
  logic [WEIGHT_W-1:0] m2_z;
  always_ff @(posedge clk) begin
    if (rst) m2_vld <= 1'b0;
    else if (en) m2_vld <= m1_vld;
    if (en) begin
      m2_z    <= m1_z;
      prod_xy <= PW'(pp[0]) + (PW'(pp[1]) << HALF_W) + (PW'(pp[2]) << HALF_W)
               + (PW'(pp[3]) << (2 * HALF_W));
    end
  end

  // M3: (x*y)*z partial products
  logic                m3_vld;
  logic [PW-1:0]       m3_xy;
  logic [2*HALF_W-1:0] qq [0:7];
  always_ff @(posedge clk) begin
    if (rst) m3_vld <= 1'b0;
    else if (en) m3_vld <= m2_vld;
    if (en) begin
      m3_xy <= prod_xy;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          qq[i*2+j] <= (2*HALF_W)'(prod_xy[HALF_W*i +: HALF_W])
                     * (2*HALF_W)'(m2_z[HALF_W*j +: HALF_W]);
        end
      end
    end
  end

  // M4: sums for the low and high half of z
  logic          m4_vld;
  logic [PW-1:0] m4_xy;
  logic [LW-1:0] sum_lo;
  logic [LW-1:0] sum_hi;
  logic [LW-1:0] sum_lo_next;
  logic [LW-1:0] sum_hi_next;
  always_comb begin
    sum_lo_next = '0;
    sum_hi_next = '0;
    for (int i = 0; i < 4; i++) begin
      sum_lo_next = sum_lo_next + (LW'(qq[i*2])   << (HALF_W * i));
      sum_hi_next = sum_hi_next + (LW'(qq[i*2+1]) << (HALF_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m4_vld <= 1'b0;
    else if (en) m4_vld <= m3_vld;
    if (en) begin
      m4_xy  <= m3_xy;
      sum_lo <= sum_lo_next;
      sum_hi <= sum_hi_next;
    end
  end

  // M5: final sum, truncate to Q.32, saturate
  logic [QW-1:0] prod_xyz;
  logic          over;
  logic [RESULT_W-1:0] val;
  assign prod_xyz = QW'(sum_lo) + (QW'(sum_hi) << HALF_W);
  always_comb begin
    if (three_d) begin
      over = |prod_xyz[QW-1:64+RESULT_W];
      val  = prod_xyz[64 +: RESULT_W];
    end else begin
      over = m4_xy[PW-1];
      val  = m4_xy[32 +: RESULT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_vld <= 1'b0;
    else if (en) res_vld <= m4_vld;
    if (en) begin
      res_weight <= over ? MAX_WEIGHT : val;
      res_sat    <= over;
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-point delta kernel testbench
// Streams grid/marker coordinate pairs through the kernel under several
// spacing and dimension settings. A scoreboard predicts each weight and its
// saturation flag, then compares them in order with the output stream.
// ----------------------------------------------------------------------------
module testbench;
  import tpd_pkg::*;

  localparam int FRAC = KERNEL_FRAC_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [RESULT_W-1:0] weight;
    logic                sat;
  } weight_t;

  // Weight predictor and in-order store of expected weights
  class weight_board;
    logic [SPACING_W-1:0] inv_spacing;
    logic [DIM_W-1:0]     dims;
    weight_t              pending[$];
    int                   mismatches;

    function new();
      inv_spacing = INV_SPACING_RST;
      dims        = DIM_3D;
      mismatches  = 0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] t);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > t) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (t >= res + bitv) begin
          t   = t - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [WEIGHT_W-1:0] axis_weight(logic [31:0] g, logic [31:0] m);
      logic signed [32:0] d;
      logic [63:0] ad, p, rf, u, s, phi, num, one, w;
      one = 64'd1 << FRAC;
      d   = $signed({g[31], g}) - $signed({m[31], m});
      ad  = (d < 0) ? 64'(-d) : 64'(d);
      p   = ad * 64'(inv_spacing);
      rf  = p >> (32 - FRAC);
      // inner branch, outer branch (64-bit wrap kept), then zero
      if (p < (64'd1 << 31)) begin
        s   = isqrt(one * one - 64'd3 * rf * rf);
        phi = (one + s) / 3;
      end else if (p <= (64'd3 << 31)) begin
        u   = (rf > one) ? rf - one : one - rf;
        s   = isqrt(one * one - 64'd3 * u * u);
        num = 64'd5 * one;
        phi = (num >= 64'd3 * rf + s) ? (num - 64'd3 * rf - s) / 6 : 64'd0;
      end else begin
        phi = 0;
      end
      w = ((phi << (24 - FRAC)) * 64'(inv_spacing)) >> 8;
      return w[WEIGHT_W-1:0];
    endfunction

    // Predict the weight of one accepted coordinate transaction
    function void note_pair(logic [191:0] c);
      logic [191:0] acc;
      weight_t      e;
      acc = 192'(axis_weight(c[31:0], c[127:96])) *
            192'(axis_weight(c[63:32], c[159:128]));
      if (dims == DIM_3D) begin
        acc   = acc * 192'(axis_weight(c[95:64], c[191:160]));
        e.sat = (acc >> 127) != 0;
        e.weight = acc[126:64];
      end else begin
        e.sat = (acc >> 95) != 0;
        e.weight = acc[94:32];
      end
      if (e.sat) e.weight = MAX_WEIGHT;
      pending.push_back(e);
    endfunction

    function void check_weight(logic [63:0] data, logic user);
      weight_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected weight %h sat %b", data, user);
        return;
      end
      e = pending.pop_front();
      if (data[RESULT_W-1:0] !== e.weight || data[63] !== 1'b0 || user !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("weight mismatch: exp %h sat %b, got %h sat %b",
                   e.weight, e.sat, data, user);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic         cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  weight_board board = new();
  int  cycles = 0;
  int  burst_left = 0;
  bit  rx_enable = 0;

  three_point_delta_kernel_top DUT (.*);

  always #5 clk = ~clk;

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: check results, stall on a changing pattern
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 97) % 4;
    if (m_axis_tvalid && m_axis_tready) board.check_weight(m_axis_tdata, m_axis_tuser);
    if (!rx_enable) m_axis_tready <= 1'b0;
    else case (mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= (cycles % 7) != 0;
      default: m_axis_tready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  // One coordinate transaction; gaps come between random bursts
  task automatic send_pair(logic [191:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tdata  <= c;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_pair(c);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (FRAC + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INV_SPACING) board.inv_spacing = val;
    else board.dims = val[DIM_W-1:0];
  endtask

  function automatic logic [191:0] pack(logic [31:0] gx, gy, gz, mx, my, mz);
    return {mz, my, mx, gz, gy, gx};
  endfunction

  // Random pair with offsets mostly inside the kernel support
  task automatic send_random(int n);
    logic [63:0] span;
    logic [31:0] m[3], g[3];
    for (int i = 0; i < n; i++) begin
      span = (board.inv_spacing == 0) ? 64'h7FFFFFFF : (64'd2 << 32) / board.inv_spacing;
      if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
      for (int a = 0; a < 3; a++) begin
        m[a] = $urandom;
        if ($urandom_range(0, 9) == 0) g[a] = $urandom;
        else begin
          g[a] = 32'($urandom_range(0, 32'(span)));
          g[a] = $urandom_range(0, 1) ? m[a] + g[a] : m[a] - g[a];
        end
      end
      send_pair(pack(g[0], g[1], g[2], m[0], m[1], m[2]));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    rx_enable = 1;

    // Directed: center, branch edges, extremes, far away (default h = 1, 3D), then other settings
    send_pair(pack(0, 0, 0, 0, 0, 0));
    send_pair(pack(32'h7FFF, 32'h8000, 32'h8001, 0, 0, 0));
    send_pair(pack(32'h10000, 32'h18000, 32'h18001, 0, 0, 0));
    send_pair(pack(0, 0, 0, 32'h17FFF, 32'h4000, 32'hC000));
    send_pair(pack(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h80000000, 32'h80000000, 32'h80000000));
    send_pair(pack(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 0));
    send_pair(pack('1, '1, '1, '1, '1, '1));
    send_pair(pack(32'h30000, 0, 0, 0, 0, 0));
    write_reg(REG_DIM_COUNT, 2);
    send_pair(pack(0, 32'h8000, 32'h7FFFFFFF, 0, 0, 0));
    send_pair(pack(32'h18000, 32'h7FFF, 32'h80000000, 0, 0, 0));
    write_reg(REG_INV_SPACING, 32'hFFFFFFFF);
    send_pair(pack(0, 0, 0, 0, 0, 0));
    send_pair(pack(1, 0, 0, 0, 1, 0));
    write_reg(REG_DIM_COUNT, 3);
    send_pair(pack(0, 0, 0, 0, 0, 0));
    send_pair(pack(0, 0, 1, 0, 0, 0));
    write_reg(REG_INV_SPACING, 0);
    send_pair(pack(0, 0, 0, 0, 0, 0));
    send_pair(pack(32'h1234, 32'h8000, 0, 0, 0, 0));
    write_reg(REG_INV_SPACING, 1);
    send_pair(pack(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0));
    send_pair(pack(0, 0, 0, 0, 0, 0));

    // Random phases across settings
    write_reg(REG_INV_SPACING, 32'h10000);
    send_random(120);
    write_reg(REG_DIM_COUNT, 0);
    send_random(60);
    write_reg(REG_INV_SPACING, 32'h100000);
    write_reg(REG_DIM_COUNT, 1);
    send_random(80);
    write_reg(REG_INV_SPACING, 32'hFFFFFFFF);
    write_reg(REG_DIM_COUNT, 3);
    send_random(80);
    write_reg(REG_DIM_COUNT, 2);
    send_random(60);
    write_reg(REG_INV_SPACING, 32'h8000);
    write_reg(REG_DIM_COUNT, 3);
    send_random(80);
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_INV_SPACING, $urandom);
      write_reg(REG_DIM_COUNT, $urandom_range(0, 3));
      send_random(55);
    end

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/tpd_pkg.sv
rtl/tpd_lane.sv
rtl/tpd_merge.sv
rtl/three_point_delta_kernel_top.sv
dv/testbench.sv
